[rtl/cbs_pkg.sv]
package cbs_pkg;

    // Configuration register
    localparam int HALF_WINDOW_BITS  = 5;
    localparam int HALF_WINDOW_RESET = 2;

    // Defaults for the top-level parameters
    localparam int MAX_HALF_WINDOW_DEF = 31;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Series bookkeeping
    localparam int SEEN_BITS  = 7;
    localparam int SEEN_MAX   = 127;
    localparam int MIN_SERIES = 3;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

[rtl/cbs_queue.sv]
module cbs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH   = cbs_pkg::QUEUE_DEPTH;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   store_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/cbs_front.sv]
module cbs_front #(
    parameter int MAX_HALF_WINDOW = cbs_pkg::MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_BITS     = cbs_pkg::SAMPLE_BITS_DEF,
    localparam int RING_DEPTH     = 2 * MAX_HALF_WINDOW + 1,
    localparam int PTR_W          = $clog2(RING_DEPTH),
    localparam int WIN_W          = $clog2(RING_DEPTH + 1),
    localparam int CMD_W          = SAMPLE_BITS + PTR_W + WIN_W + 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [cbs_pkg::HALF_WINDOW_BITS-1:0]  half_window,
    input  logic                                  cfg_we,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  logic                                  s_last_sample,
    output logic                                  cmd_push,
    output logic [CMD_W-1:0]                      cmd_data,
    input  logic                                  cmd_ready
);

    localparam int SB = cbs_pkg::SEEN_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [PTR_W-1:0]              ptr;
        logic [WIN_W-1:0]              div;
        logic                          sub_old;
        logic                          err;
        logic                          emit;
        logic                          last;
    } cmd_t;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [SB-1:0]    seen_reg, seen_next;
    logic [WIN_W-1:0] nwin;
    logic [SB-1:0]    nwin_wide;
    logic [PTR_W-1:0] ptr_cur;
    logic [SB-1:0]    seen_inc;
    cmd_t             cmd;

    assign s_ready  = cmd_ready;
    assign cmd_push = s_valid && cmd_ready;
    assign cmd_data = cmd;

    // Classify the request against the series position
    always_comb begin
        nwin      = WIN_W'({half_window, 1'b1});
        nwin_wide = SB'(nwin);
        ptr_cur   = (WIN_W'(ptr_reg) >= nwin) ? '0 : ptr_reg;
        seen_inc  = (seen_reg == SB'(cbs_pkg::SEEN_MAX)) ? seen_reg : seen_reg + SB'(1);

        cmd.sample  = s_sample;
        cmd.ptr     = ptr_cur;
        cmd.sub_old = (seen_reg >= nwin_wide);
        cmd.err     = s_last_sample &&
                      ((seen_inc < SB'(cbs_pkg::MIN_SERIES)) || (seen_inc < nwin_wide));
        cmd.emit    = (seen_inc > SB'(half_window));
        cmd.div     = (seen_inc < nwin_wide) ? WIN_W'(seen_inc) : nwin;
        cmd.last    = s_last_sample;

        ptr_next  = ptr_reg;
        seen_next = seen_reg;
        if (cmd_push) begin
            if (s_last_sample) begin
                ptr_next  = '0;
                seen_next = '0;
            end else begin
                ptr_next  = (WIN_W'(ptr_cur) + WIN_W'(1) == nwin) ? '0
                                                                  : ptr_cur + PTR_W'(1);
                seen_next = seen_inc;
            end
        end
    end

    // Restart the series on reset or a register write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            ptr_reg  <= '0;
            seen_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[rtl/cbs_div.sv]
module cbs_div #(
    parameter int SAMPLE_BITS = cbs_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_W       = 22,
    parameter int WIN_W       = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       sum,
    input  logic [WIN_W-1:0]              cnt,
    output logic                          busy,
    output logic signed [SAMPLE_BITS-1:0] quot
);

    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = WIN_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic [SUM_W-1:0]  mag;
    logic [REM_W-1:0]  rem_sh;
    logic              fits;
    logic [NUM_W-1:0]  q_signed;

    assign busy = busy_reg;

    // Form magnitude, shifted remainder and signed quotient
    always_comb begin
        mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        rem_sh   = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        fits     = (rem_sh >= REM_W'(den_reg));
        q_signed = neg_reg ? (~num_reg + NUM_W'(1)) : num_reg;
        quot     = q_signed[SAMPLE_BITS-1:0];
    end

    // Control: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            busy_reg <= (step_reg != STEP_W'(1));
        end
    end

    // Datapath: restoring division of (2|s| + c) by 2c
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {mag, 1'b0} + NUM_W'(cnt);
            den_reg <= {cnt, 1'b0};
            rem_reg <= '0;
            neg_reg <= sum[SUM_W-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_sh - REM_W'(den_reg)) : rem_sh;
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

endmodule

[rtl/cbs_back.sv]
module cbs_back #(
    parameter int MAX_HALF_WINDOW = cbs_pkg::MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_BITS     = cbs_pkg::SAMPLE_BITS_DEF,
    localparam int RING_DEPTH     = 2 * MAX_HALF_WINDOW + 1,
    localparam int PTR_W          = $clog2(RING_DEPTH),
    localparam int WIN_W          = $clog2(RING_DEPTH + 1),
    localparam int CMD_W          = SAMPLE_BITS + PTR_W + WIN_W + 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [cbs_pkg::HALF_WINDOW_BITS-1:0]  half_window,
    input  logic                                  cfg_we,
    input  logic                                  cmd_valid,
    input  logic [CMD_W-1:0]                      cmd_data,
    output logic                                  cmd_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_smoothed,
    output logic                                  m_last_result,
    output logic                                  m_error
);

    localparam int SUM_W = SAMPLE_BITS + WIN_W;
    localparam int HW_W  = cbs_pkg::HALF_WINDOW_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_FUPD = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [PTR_W-1:0]              ptr;
        logic [WIN_W-1:0]              div;
        logic                          sub_old;
        logic                          err;
        logic                          emit;
        logic                          last;
    } cmd_t;

    logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg;

    logic [2:0]              state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [PTR_W-1:0]        fptr_reg, fptr_next;
    logic [WIN_W-1:0]        cnt_reg, cnt_next;
    logic [HW_W-1:0]         left_reg, left_next;
    logic                    err_reg, err_next;
    logic                    last_reg, last_next;

    logic                          mv_reg, mv_next;
    logic signed [SAMPLE_BITS-1:0] smoothed_reg, smoothed_next;
    logic                          lastres_reg, lastres_next;
    logic                          error_reg, error_next;

    logic                          rd_en, wr_en;
    logic [PTR_W-1:0]              rd_addr;
    logic                          div_start, div_busy;
    logic signed [SUM_W-1:0]       div_sum;
    logic [WIN_W-1:0]              div_cnt;
    logic signed [SAMPLE_BITS-1:0] div_q;
    logic [WIN_W-1:0]              nwin;
    logic signed [SUM_W-1:0]       sum_upd;
    logic                          out_free;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                                 input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] p_inc;
        p_inc = WIN_W'(p) + WIN_W'(1);
        return (p_inc == w) ? '0 : p + PTR_W'(1);
    endfunction

    cbs_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .WIN_W       (WIN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (div_sum),
        .cnt     (div_cnt),
        .busy    (div_busy),
        .quot    (div_q)
    );

    assign m_valid       = mv_reg;
    assign m_smoothed    = smoothed_reg;
    assign m_last_result = lastres_reg;
    assign m_error       = error_reg;

    // Sequence update, division and edge flush
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        fptr_next     = fptr_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        mv_next       = mv_reg;
        smoothed_next = smoothed_reg;
        lastres_next  = lastres_reg;
        error_next    = error_reg;
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = fptr_reg;
        wr_en         = 1'b0;
        div_start     = 1'b0;
        div_sum       = sum_reg;
        div_cnt       = cnt_reg;
        nwin          = WIN_W'({half_window, 1'b1});
        out_free      = !mv_reg || m_ready;
        sum_upd       = sum_reg - (cmd_reg.sub_old ? SUM_W'(rd_reg) : '0)
                        + SUM_W'($signed(cmd_reg.sample));

        // Drop the result once taken
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_t'(cmd_data);
                    rd_en      = 1'b1;
                    rd_addr    = cmd_next.ptr;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                wr_en     = 1'b1;
                last_next = cmd_reg.last;
                err_next  = cmd_reg.err;
                fptr_next = ptr_adv(cmd_reg.ptr, nwin);
                cnt_next  = nwin;
                left_next = (cmd_reg.last && !cmd_reg.err) ? half_window : '0;
                if (cmd_reg.err) begin
                    sum_next   = '0;
                    state_next = S_PUT;
                end else if (cmd_reg.emit) begin
                    sum_next   = sum_upd;
                    div_start  = 1'b1;
                    div_sum    = sum_upd;
                    div_cnt    = cmd_reg.div;
                    state_next = S_DIV;
                end else begin
                    sum_next   = sum_upd;
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    mv_next       = 1'b1;
                    smoothed_next = err_reg ? '0 : div_q;
                    lastres_next  = last_reg && (left_reg == '0);
                    error_next    = err_reg;
                    if (left_reg != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = fptr_reg;
                        state_next = S_FUPD;
                    end else begin
                        if (last_reg) begin
                            sum_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_FUPD: begin
                sum_next   = sum_reg - SUM_W'(rd_reg);
                cnt_next   = cnt_reg - WIN_W'(1);
                fptr_next  = ptr_adv(fptr_reg, nwin);
                left_next  = left_reg - HW_W'(1);
                div_start  = 1'b1;
                div_sum    = sum_next;
                div_cnt    = cnt_next;
                state_next = S_DIV;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Abandon the series on a register write
        if (cfg_we) begin
            sum_next = '0;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            left_reg  <= '0;
            last_reg  <= 1'b0;
            err_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
            mv_reg    <= mv_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        fptr_reg     <= fptr_next;
        cnt_reg      <= cnt_next;
        smoothed_reg <= smoothed_next;
        lastres_reg  <= lastres_next;
        error_reg    <= error_next;
    end

    // Ring buffer: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[cmd_reg.ptr] <= cmd_reg.sample;
        end
        if (rd_en) begin
            rd_reg <= ring[rd_addr];
        end
    end

    // Never restart the divider while it works
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // An error result always closes the series
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && error_reg) |-> lastres_reg)
        else $error("error result without last flag");

    // Flush work only belongs to a closing series
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != '0) |-> (last_reg && !err_reg))
        else $error("flush pending outside a closing series");

    // Flush divisor never shrinks below h+1
    a_flush_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FUPD) |-> (cnt_reg > WIN_W'(half_window) + WIN_W'(1)))
        else $error("flush divisor underflow");

    // Leaving the output stage always moves a result
    a_put_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUT && state_next != S_PUT) |=> mv_reg)
        else $error("output stage left without a result");

endmodule

[rtl/centered_boxcar_smoother.sv]
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_data (half window)
// s         in         s_valid/s_ready       s_sample, s_last_sample
// m         out        m_valid/m_ready       m_smoothed, m_last_result, m_error
//
// Each mean comes from the bit-serial divider, one quotient bit per cycle; an
// error result skips the divider. A request that gives no result passes the back
// end through its IDLE and UPD states.
// Reset is synchronous, active low, and sets the half window to 2.
// A two-entry queue takes requests while the back end or the output waits.
module centered_boxcar_smoother #(
    parameter int MAX_HALF_WINDOW = cbs_pkg::MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_BITS     = cbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cbs_pkg::HALF_WINDOW_BITS-1:0]  cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  logic                                  s_last_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_smoothed,
    output logic                                  m_last_result,
    output logic                                  m_error
);

    localparam int RING_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int WIN_W      = $clog2(RING_DEPTH + 1);
    localparam int CMD_W      = SAMPLE_BITS + PTR_W + WIN_W + 4;
    localparam int HW_W       = cbs_pkg::HALF_WINDOW_BITS;
    localparam logic [HW_W-1:0] HW_RESET =
        HW_W'((cbs_pkg::HALF_WINDOW_RESET > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW
                                                             : cbs_pkg::HALF_WINDOW_RESET);

    logic [HW_W-1:0]  half_window_reg, half_window_next;
    logic             cfg_we;
    logic             cmd_push, cmd_push_ready;
    logic [CMD_W-1:0] cmd_in, cmd_out;
    logic             cmd_valid, cmd_pop;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Cap the written half window
    always_comb begin
        half_window_next = half_window_reg;
        if (cfg_we) begin
            half_window_next = (int'(cfg_data) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                                  : cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_window_reg <= HW_RESET;
        end else begin
            half_window_reg <= half_window_next;
        end
    end

    cbs_front #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .half_window   (half_window_reg),
        .cfg_we        (cfg_we),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in),
        .cmd_ready     (cmd_push_ready)
    );

    cbs_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_data  (cmd_in),
        .push_ready (cmd_push_ready),
        .pop        (cmd_pop),
        .pop_valid  (cmd_valid),
        .pop_data   (cmd_out)
    );

    cbs_back #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .half_window   (half_window_reg),
        .cfg_we        (cfg_we),
        .cmd_valid     (cmd_valid),
        .cmd_data      (cmd_out),
        .cmd_pop       (cmd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_smoothed    (m_smoothed),
        .m_last_result (m_last_result),
        .m_error       (m_error)
    );

endmodule

[test/tb_centered_boxcar_smoother.sv]
`timescale 1ns / 1ps

module tb_centered_boxcar_smoother;

    localparam int SMP_W        = cbs_pkg::SAMPLE_BITS_DEF;
    localparam int RING_N       = 2 * cbs_pkg::MAX_HALF_WINDOW_DEF + 1;
    localparam int HW_BITS      = cbs_pkg::HALF_WINDOW_BITS;
    localparam int SUM_BITS     = 22;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_ITEM = 40;

    typedef struct {
        logic signed [SMP_W-1:0] x;
        logic                    is_last;
    } sample_req_t;

    typedef struct {
        logic signed [SMP_W-1:0] smoothed;
        logic                    last_result;
        logic                    error;
    } smooth_res_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [HW_BITS-1:0]          cfg_data      = '0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [SMP_W-1:0]     s_sample      = '0;
    logic                        s_last_sample = 1'b0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic signed [SMP_W-1:0]     m_smoothed;
    logic                        m_last_result;
    logic                        m_error;

    centered_boxcar_smoother dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_smoothed    (m_smoothed),
        .m_last_result (m_last_result),
        .m_error       (m_error)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Smoother state mirrored by the predictor
    logic signed [SMP_W-1:0]          win_ring [RING_N];
    logic signed [SUM_BITS-1:0]       win_sum;
    logic [5:0]                       win_ptr;
    logic [cbs_pkg::SEEN_BITS-1:0]    win_seen;
    logic [HW_BITS-1:0]               half_win;

    smooth_res_t smooth_q [$];
    sample_req_t req_q [$];
    sample_req_t req_cur;
    smooth_res_t res_want;

    int  n_pushed = 0;
    int  n_taken  = 0;
    int  n_fail   = 0;
    bit  idle_on  = 1'b1;

    function automatic logic signed [SMP_W-1:0] round_mean(longint s, int cnt);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q   = (2 * mag + cnt) / (2 * cnt);
        return SMP_W'((s < 0) ? -q : q);
    endfunction

    function automatic void expect_mean(longint s, int cnt, logic fin);
        smooth_q.push_back('{round_mean(s, cnt), fin, 1'b0});
    endfunction

    function automatic void restart_series();
        win_sum  = '0;
        win_ptr  = '0;
        win_seen = '0;
    endfunction

    function automatic void step_ptr(int nwin);
        if (win_ptr + 1 >= nwin) begin
            win_ptr = '0;
        end else begin
            win_ptr = win_ptr + 1'b1;
        end
    endfunction

    // Work out the results that one sample request causes
    function automatic void predict_sample(logic signed [SMP_W-1:0] x, logic fin);
        int h;
        int nwin;
        int n;
        int cnt;
        int j;
        h    = half_win;
        nwin = 2 * h + 1;
        if (win_ptr >= nwin) begin
            win_ptr = '0;
        end
        if (win_seen >= nwin) begin
            win_sum = win_sum - win_ring[win_ptr];
        end
        win_ring[win_ptr] = x;
        win_sum = win_sum + x;
        step_ptr(nwin);
        if (win_seen < cbs_pkg::SEEN_MAX) begin
            win_seen = win_seen + 1'b1;
        end
        n = win_seen;
        if (fin && (n < cbs_pkg::MIN_SERIES || n < nwin)) begin
            // short series: one flagged result, drop the series
            smooth_q.push_back('{'0, 1'b1, 1'b1});
            restart_series();
        end else begin
            if (n > h) begin
                expect_mean(win_sum, (n < nwin) ? n : nwin, fin && h == 0);
            end
            if (fin) begin
                // flush the tail with a shrinking divisor
                cnt = nwin;
                for (j = 0; j < h; j++) begin
                    win_sum = win_sum - win_ring[win_ptr];
                    step_ptr(nwin);
                    cnt--;
                    expect_mean(win_sum, cnt, j == h - 1);
                end
                restart_series();
            end
        end
    endfunction

    // Drive sample requests from the pending queue
    int s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sample(s_sample, s_last_sample);
                n_taken++;
            end
            // hold a request until it is taken
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    s_gap = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    req_cur = req_q.pop_front();
                    s_sample      <= req_cur.x;
                    s_last_sample <= req_cur.is_last;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check results and pace the result channel
    int m_gap  = 0;
    int m_hold = 0;
    bit held_long = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (smooth_q.size() == 0) begin
                    $display("%0t: unexpected result smoothed %0d last %0b error %0b",
                             $time, m_smoothed, m_last_result, m_error);
                    n_fail++;
                end else begin
                    res_want = smooth_q.pop_front();
                    if (m_smoothed !== res_want.smoothed) begin
                        $display("%0t: smoothed expected %0d actual %0d",
                                 $time, res_want.smoothed, m_smoothed);
                        n_fail++;
                    end
                    if (m_last_result !== res_want.last_result) begin
                        $display("%0t: last_result expected %0b actual %0b",
                                 $time, res_want.last_result, m_last_result);
                        n_fail++;
                    end
                    if (m_error !== res_want.error) begin
                        $display("%0t: error expected %0b actual %0b",
                                 $time, res_want.error, m_error);
                        n_fail++;
                    end
                end
            end
            // back up the block once while the sender keeps offering
            if (!held_long && n_taken >= HOLD_AT_ITEM) begin
                held_long = 1'b1;
                m_hold = LONG_HOLD;
            end
            if (m_hold > 0) begin
                m_hold--;
                m_ready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_gap = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_req(logic signed [SMP_W-1:0] x, logic fin);
        req_q.push_back('{x, fin});
        n_pushed++;
    endtask

    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: begin
                return 16'sh7fff;
            end
            1: begin
                return 16'sh8000;
            end
            default: begin
                return SMP_W'($urandom);
            end
        endcase
    endfunction

    task automatic push_series(int len);
        int i;
        for (i = 0; i < len; i++) begin
            push_req(random_sample(), i == len - 1);
        end
    endtask

    // Mostly well-formed series, some cut short
    task automatic gen_phase(int target);
        int k;
        int len;
        int min_len;
        k = 0;
        min_len = 2 * half_win + 1;
        if (min_len < cbs_pkg::MIN_SERIES) begin
            min_len = cbs_pkg::MIN_SERIES;
        end
        while (k < target) begin
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, min_len - 1);
            end else begin
                len = $urandom_range(min_len, min_len + 8);
            end
            push_series(len);
            k += len;
        end
    endtask

    // Wait until every request is taken and every result is back
    task automatic drain();
        while (n_taken != n_pushed || smooth_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_half(logic [HW_BITS-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        half_win = v;
        restart_series();
    endtask

    // Stimulus
    initial begin
        int i;
        half_win = HW_BITS'(cbs_pkg::HALF_WINDOW_RESET);
        restart_series();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // full-scale series at the reset half window
        for (i = 0; i < 5; i++) begin
            push_req(16'sh7fff, i == 4);
        end
        for (i = 0; i < 5; i++) begin
            push_req(16'sh8000, i == 4);
        end
        // fewer than three samples
        push_req(16'sd100, 1'b0);
        push_req(-16'sd100, 1'b1);
        // shorter than the window
        push_req(16'sd0, 1'b0);
        push_req(-16'sd1, 1'b0);
        push_req(16'sd1, 1'b0);
        push_req(16'sd7, 1'b1);
        // small samples of both signs for the rounding
        push_req(16'sd1, 1'b0);
        push_req(16'sd2, 1'b0);
        push_req(-16'sd1, 1'b0);
        push_req(-16'sd2, 1'b0);
        push_req(16'sd3, 1'b0);
        push_req(-16'sd3, 1'b1);
        drain();

        // window of one
        set_half(5'd0);
        push_req(16'sh8000, 1'b1);
        push_req(16'sh7fff, 1'b0);
        push_req(-16'sd1, 1'b0);
        push_req(16'sd1, 1'b1);
        gen_phase(20);
        drain();

        set_half(5'd1);
        gen_phase(10);
        drain();

        // widest window
        set_half(5'd31);
        push_series(2);
        push_series($urandom_range(63, 66));
        drain();

        set_half(5'd5);
        gen_phase(10);
        drain();

        set_half(HW_BITS'($urandom_range(2, 9)));
        gen_phase(10);
        drain();

        // final stretch at full rate
        idle_on = 1'b0;
        set_half(5'd3);
        gen_phase(10);
        drain();

        if (smooth_q.size() != 0) begin
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
